[rtl/bdasc_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the binary to decimal ASCII converter.
// No dependencies; the interface and the top level refer to it by scoped names.
package bdasc_pkg;

   // Fixed field widths of the transactions
   localparam int NUMBER_W = 64;
   localparam int CHAR_W   = 6;

   // ASCII code of '0'
   localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

   // Double-dabble bits consumed per iteration of the shared unit
   localparam int STEP_BITS = 4;

   typedef struct packed {
      logic [NUMBER_W-1:0] number;
   } req_payload_type;

   typedef struct packed {
      logic [CHAR_W-1:0] digit_char;
      logic              last_digit;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_FIND,
      ST_EMIT
   } state_type;

endpackage

[rtl/bdasc_stream_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel carrying one payload per transaction.
// Payload types come from bdasc_pkg.
interface bdasc_stream_if #(
   parameter type payload_type = bdasc_pkg::req_payload_type
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[rtl/binary_to_decimal_ascii.sv]
`timescale 1ns / 1ps
// Top level of the binary to decimal ASCII converter.
// Depends on bdasc_pkg (types, constants) and bdasc_stream_if (channels).
//
//   Channel      Dir  Payload                        Transaction
//   req_stream   in   number[63:0]                   one value to convert
//   rsp_stream   out  digit_char[5:0], last_digit    one ASCII digit, MSD first
//
// An item first passes through the double-dabble unit (ST_CONVERT), then the
// leading digit is located (ST_FIND), then the digits go out one per transaction
// (ST_EMIT), most significant first.
// The shared add-3/shift unit, four bits per cycle, sets the conversion time.
// Synchronous active-high reset clears the sequencer and the output valid.
// Output stalls hold the current digit; req_stream.ready is high only when idle.
module binary_to_decimal_ascii #(
   parameter int VALUE_BITS = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   bdasc_stream_if.sink            req_stream,
   bdasc_stream_if.source          rsp_stream
);

   // Decimal digits needed for VALUE_BITS: floor(bits * log10(2)) + 1
   localparam int DIGITS  = (VALUE_BITS * 1233) / 4096 + 1;
   localparam int BCD_W   = DIGITS * 4;
   localparam int STEPS   = (VALUE_BITS + bdasc_pkg::STEP_BITS - 1) / bdasc_pkg::STEP_BITS;
   localparam int PAD_W   = STEPS * bdasc_pkg::STEP_BITS;
   localparam int STEP_CW = (STEPS > 1) ? $clog2(STEPS) : 1;
   localparam int IDX_W   = $clog2(DIGITS);

   bdasc_pkg::state_type state_ff, state_in;

   logic [PAD_W-1:0]   value_ff, value_in;    // binary bits still to shift in
   logic [BCD_W-1:0]   bcd_ff,   bcd_in;      // packed BCD accumulator
   logic [STEP_CW-1:0] step_ff,  step_in;     // iterations left after the current one
   logic [IDX_W-1:0]   idx_ff,   idx_in;      // digit to emit next

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [bdasc_pkg::CHAR_W-1:0]  rsp_char_ff,  rsp_char_in;
   logic                          rsp_last_ff,  rsp_last_in;

   logic [PAD_W-1:0] value_step;
   logic [BCD_W-1:0] bcd_step;
   logic [IDX_W-1:0] msd_idx;
   logic             accept;
   logic             load_digit;
   logic [3:0]       sel_digit;

   assign accept     = req_stream.valid && req_stream.ready;
   assign load_digit = (state_ff == bdasc_pkg::ST_EMIT) && (!rsp_valid_ff || rsp_stream.ready);
   assign sel_digit  = bcd_ff[{idx_ff, 2'b00} +: 4];

   // Shared unit: STEP_BITS rounds of add-3 then shift, MSB of the value first
   always_comb begin
      logic [PAD_W-1:0] v;
      logic [BCD_W-1:0] b;
      v = value_ff;
      b = bcd_ff;
      for (int s = 0; s < bdasc_pkg::STEP_BITS; s++) begin
         for (int d = 0; d < DIGITS; d++) begin
            if (b[d*4 +: 4] >= 4'd5) begin
               b[d*4 +: 4] = b[d*4 +: 4] + 4'd3;
            end
         end
         b = {b[BCD_W-2:0], v[PAD_W-1]};
         v = {v[PAD_W-2:0], 1'b0};
      end
      value_step = v;
      bcd_step   = b;
   end

   // Leading non-zero digit; zero when the whole value is zero
   always_comb begin
      msd_idx = '0;
      for (int d = 0; d < DIGITS; d++) begin
         if (bcd_ff[d*4 +: 4] != 4'd0) begin
            msd_idx = IDX_W'(d);
         end
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bdasc_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = bdasc_pkg::ST_CONVERT;
            end
         end
         bdasc_pkg::ST_CONVERT: begin
            if (step_ff == '0) begin
               state_in = bdasc_pkg::ST_FIND;
            end
         end
         bdasc_pkg::ST_FIND: begin
            state_in = bdasc_pkg::ST_EMIT;
         end
         bdasc_pkg::ST_EMIT: begin
            if (load_digit && idx_ff == '0) begin
               state_in = bdasc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bdasc_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath and output controls
   always_comb begin
      value_in     = value_ff;
      bcd_in       = bcd_ff;
      step_in      = step_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_stream.ready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      req_stream.ready = 1'b0;
      case (state_ff)
         bdasc_pkg::ST_IDLE: begin
            req_stream.ready = 1'b1;
            // Mask the value to VALUE_BITS and clear the accumulator
            value_in = PAD_W'(req_stream.payload.number[VALUE_BITS-1:0]);
            bcd_in   = '0;
            step_in  = STEP_CW'(STEPS - 1);
         end
         bdasc_pkg::ST_CONVERT: begin
            value_in = value_step;
            bcd_in   = bcd_step;
            step_in  = step_ff - 1'b1;
         end
         bdasc_pkg::ST_FIND: begin
            idx_in = msd_idx;
         end
         bdasc_pkg::ST_EMIT: begin
            if (load_digit) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = bdasc_pkg::ASCII_ZERO + {2'b00, sel_digit};
               rsp_last_in  = (idx_ff == '0);
               idx_in       = idx_ff - 1'b1;
            end
         end
         default: begin
            req_stream.ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bdasc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and working registers, no reset needed
   always_ff @(posedge clock) begin
      value_ff    <= value_in;
      bcd_ff      <= bcd_in;
      step_ff     <= step_in;
      idx_ff      <= idx_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_stream.valid              = rsp_valid_ff;
   assign rsp_stream.payload.digit_char = rsp_char_ff;
   assign rsp_stream.payload.last_digit = rsp_last_ff;

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for binary_to_decimal_ascii: feeds 64-bit values, predicts digit runs.
// Depends on bdasc_pkg and bdasc_stream_if from the RTL; nothing else is read or needed.
module testbench;

   localparam int VALUE_BITS       = 64;
   localparam int HALF_PERIOD_NS   = 4;
   localparam int RESET_CYCLES     = 7;
   localparam int RANDOM_VALUES    = 220;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int WATCHDOG_LIMIT   = 3000;
   // Wait after draining, before the verdict is given
   localparam int SETTLE_CYCLES    = 40;

   // Expected digit runs, oldest first. One entry per digit transaction.
   class digit_scoreboard;
      bdasc_pkg::rsp_payload_type         expected_digits[$];
      logic [bdasc_pkg::NUMBER_W-1:0]     value_mask;
      int unsigned                        mismatches;

      function new(int value_bits);
         value_mask = (value_bits >= bdasc_pkg::NUMBER_W) ? '1
                                                          : ((64'd1 << value_bits) - 64'd1);
         mismatches = 0;
      endfunction

      // Split the masked value into decimal digits, most significant first
      function void note_number(logic [bdasc_pkg::NUMBER_W-1:0] number);
         logic [bdasc_pkg::NUMBER_W-1:0] rest;
         logic [3:0]                     digits[$];
         bdasc_pkg::rsp_payload_type     digit;
         rest = number & value_mask;
         do begin
            digits.push_front(4'(rest % 64'd10));
            rest = rest / 64'd10;
         end while (rest != 0);
         foreach (digits[k]) begin
            digit.digit_char = bdasc_pkg::ASCII_ZERO + {2'b00, digits[k]};
            digit.last_digit = (k == digits.size() - 1);
            expected_digits.push_back(digit);
         end
      endfunction

      function void check_digit(bdasc_pkg::rsp_payload_type got);
         bdasc_pkg::rsp_payload_type want;
         if (expected_digits.size() == 0) begin
            $display("%0t: digit with nothing pending: expected none, actual char %0d last %0b",
                     $time, got.digit_char, got.last_digit);
            mismatches++;
            return;
         end
         want = expected_digits.pop_front();
         if (got.digit_char !== want.digit_char) begin
            $display("%0t: digit_char expected %0d, actual %0d",
                     $time, want.digit_char, got.digit_char);
            mismatches++;
         end
         if (got.last_digit !== want.last_digit) begin
            $display("%0t: last_digit expected %0b, actual %0b",
                     $time, want.last_digit, got.last_digit);
            mismatches++;
         end
      endfunction

      function int pending();
         return expected_digits.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   bdasc_stream_if #(.payload_type(bdasc_pkg::req_payload_type)) req_if ();
   bdasc_stream_if #(.payload_type(bdasc_pkg::rsp_payload_type)) rsp_if ();

   digit_scoreboard board;

   // Idle percentages for each side; the stimulus process moves them between phases
   int send_idle_pct;
   int rsp_idle_pct;
   // Raised by the stimulus to ask the receiver for one long hold-off
   bit long_hold_request = 1'b0;
   // Cycles since the last transaction on either channel
   int idle_cycles = 0;

   binary_to_decimal_ascii #(
      .VALUE_BITS(VALUE_BITS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_stream (req_if),
      .rsp_stream (rsp_if)
   );

   always #(HALF_PERIOD_NS) clock = ~clock;

   // Monitor: every transaction is seen here, at the edge that moves it.
   // Values accepted on the request side are predicted at once; digits are checked in order.
   always @(posedge clock) begin
      idle_cycles = idle_cycles + 1;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            board.note_number(req_if.payload.number);
            idle_cycles = 0;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            board.check_digit(rsp_if.payload);
            idle_cycles = 0;
         end
      end
   end

   // Watchdog: end the run if the block stops moving
   initial begin : watchdog
      do @(posedge clock); while (idle_cycles < WATCHDOG_LIMIT);
      $display("FAIL");
      $finish;
   end

   // Receiver: stall at random, or hold off for a long stretch on request so that
   // the block stalls with its request ready low
   initial begin : rsp_driver
      int hold_left;
      hold_left = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_request) begin
            long_hold_request = 1'b0;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99, 0) >= rsp_idle_pct);
         end
      end
   end

   // Offer one value, idling first at random; return at the edge that accepts it.
   // Valid is left high so that the next value can follow without a gap.
   task automatic send_number(input logic [bdasc_pkg::NUMBER_W-1:0] number);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid          <= 1'b1;
      req_if.payload.number <= number;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // Drop valid and hold the sender until every predicted digit has arrived
   task automatic drain_digits();
      req_if.valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      logic [bdasc_pkg::NUMBER_W-1:0] number;
      logic [bdasc_pkg::NUMBER_W-1:0] power;
      board = new(VALUE_BITS);
      reset                 <= 1'b1;
      req_if.valid          <= 1'b0;
      req_if.payload.number <= '0;
      send_idle_pct = 16;
      rsp_idle_pct  = 52;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed values: zero, digit-count boundaries, the 32-bit edge, the full range
      send_number(64'd0);
      send_number(64'd1);
      send_number(64'd9);
      send_number(64'd10);
      send_number(64'd99);
      send_number(64'd100);
      send_number(64'd1234567890);
      send_number(64'h0000_0000_FFFF_FFFF);
      send_number(64'h0000_0001_0000_0000);
      send_number(64'd9999999999999999999);
      send_number(64'd10000000000000000000);
      send_number(64'h8000_0000_0000_0000);
      send_number(64'h8000_0000_0000_0001);
      send_number(64'hAAAA_AAAA_AAAA_AAAA);
      send_number(64'h5555_5555_5555_5555);
      send_number(64'hFFFF_FFFF_FFFF_FFFE);
      send_number(64'hFFFF_FFFF_FFFF_FFFF);
      drain_digits();

      for (int i = 0; i < RANDOM_VALUES; i++) begin
         // Swap the idling between sides, then run flat out
         if (i == RANDOM_VALUES / 3) begin
            drain_digits();
            send_idle_pct = 52;
            rsp_idle_pct  = 16;
         end
         if (i == 2 * RANDOM_VALUES / 3) begin
            drain_digits();
            send_idle_pct = 0;
            rsp_idle_pct  = 0;
         end
         if (i == 20) long_hold_request = 1'b1;

         case ($urandom_range(3, 0))
            0: number = {$urandom, $urandom};
            // Shorten the value to spread the digit count evenly
            1: number = {$urandom, $urandom} >> $urandom_range(63, 0);
            // Powers of ten and the value just below them
            2: begin
               power = 64'd1;
               repeat ($urandom_range(19, 0)) power = power * 64'd10;
               number = power - $urandom_range(1, 0);
            end
            default: number = $urandom_range(999, 0);
         endcase
         send_number(number);
      end

      drain_digits();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/bdasc_pkg.sv
rtl/bdasc_stream_if.sv
rtl/binary_to_decimal_ascii.sv
tb/sv/testbench.sv
